### sv/quaternion_normalizer_unit_defines.svh
`ifndef QUATERNION_NORMALIZER_UNIT_DEFINES_SVH
`define QUATERNION_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle check, held off during reset
`define QN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qn assertion failed");

// next-cycle check, held off during reset
`define QN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qn assertion failed");

`endif

### sv/qn_pkg.sv
package qn_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int COMP_BITS   = 32;
    localparam int REG_BITS    = 29;
    localparam int CFG_IDX_BITS = 2;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STEPS   = 29;
    localparam int DIV_LAT     = DIV_STEPS + 1;
    localparam int M_TAP       = SQRT_STAGES - 1;
    localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_LAT;

    localparam logic [REG_BITS-1:0] LIM_RESET = 29'd26844;
    localparam logic [REG_BITS-1:0] TOL_RESET = 29'd2684355;
    localparam logic [COMP_BITS-1:0] ONE_Q28  = 32'h1000_0000;
    localparam logic [64:0] ONE_Q56 = 65'h0_0100_0000_0000_0000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_ZERO = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNIT_TOL  = 2'd1;

    typedef enum logic [1:0] {
        OUT_UNCHANGED = 2'd0,
        OUT_IDENTITY  = 2'd1,
        OUT_RESCALED  = 2'd2
    } t_outcome;

    typedef logic [3:0][COMP_BITS-1:0] t_quat;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        t_quat                 comp;
    } t_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        t_quat                 comp;
        logic                  near_zero;
        logic                  carry;
        logic                  zero;
        logic                  off_unit;
    } t_side;

endpackage

### sv/qn_square_lane.sv
module qn_square_lane import qn_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [COMP_BITS-1:0] i_comp,
    output logic [2*COMP_BITS-1:0]      o_sq
);

    logic [COMP_BITS-1:0]   mag;
    logic [2*COMP_BITS-1:0] r_sq;

    assign mag = i_comp[COMP_BITS-1] ? (~i_comp + 1'b1) : i_comp;

    always_ff @(posedge i_clk) begin
        r_sq <= mag * mag;
    end

    assign o_sq = r_sq;

endmodule

### sv/qn_isqrt.sv
module qn_isqrt import qn_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [0:SQRT_STAGES-1];
    logic [31:0] r_root [0:SQRT_STAGES-1];
    logic [63:0] r_rad  [0:SQRT_STAGES-1];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign rem_sh = {rem_in, rad_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (rem_sh >= trial) begin
                r_rem[k]  <= 34'(rem_sh - trial);
                r_root[k] <= {root_in[30:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh[33:0];
                r_root[k] <= {root_in[30:0], 1'b0};
            end
            r_rad[k] <= {rad_in[61:0], 2'b00};
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

### sv/qn_div_lane.sv
module qn_div_lane import qn_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [COMP_BITS-1:0] i_comp,
    input  logic [32:0]                 i_mag,
    output logic [DIV_STEPS-1:0]        o_quot
);

    logic [COMP_BITS-1:0] abs_c;
    logic [59:0]          num;

    logic [32:0]          r_rem  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_low  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quot [0:DIV_STEPS];
    logic [32:0]          r_div  [0:DIV_STEPS];

    assign abs_c = i_comp[COMP_BITS-1] ? (~i_comp + 1'b1) : i_comp;
    assign num   = {abs_c, 28'b0} + 60'(i_mag >> 1);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {2'b00, num[59:DIV_STEPS]};
        r_low[0]  <= num[DIV_STEPS-1:0];
        r_quot[0] <= '0;
        r_div[0]  <= i_mag;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [33:0] rem_sh;

        assign rem_sh = {r_rem[k-1], r_low[k-1][DIV_STEPS-1]};

        always_ff @(posedge i_clk) begin
            if (rem_sh >= {1'b0, r_div[k-1]}) begin
                r_rem[k]  <= 33'(rem_sh - {1'b0, r_div[k-1]});
                r_quot[k] <= {r_quot[k-1][DIV_STEPS-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh[32:0];
                r_quot[k] <= {r_quot[k-1][DIV_STEPS-2:0], 1'b0};
            end
            r_low[k] <= {r_low[k-1][DIV_STEPS-2:0], 1'b0};
            r_div[k] <= r_div[k-1];
        end
    end

    assign o_quot = r_quot[DIV_STEPS];

endmodule

### sv/quaternion_normalizer_unit.sv
// channel   direction  handshake                      word
// input     in         i_start & !o_busy              index, w, x, y, z
// result    out        o_done, one cycle, no stall    index, w, x, y, z, outcome
// config    in         i_cfg_valid & o_cfg_ready      register index, data
//
// One word accepted every cycle; o_busy is never raised.
// Stages after the input register: 3 stages for squares
// and sum, 32 for the square root (one root bit each), 30 for the lane
// dividers (an input register, then one quotient bit each), 1 output register.
// Synchronous active-low reset clears valids and loads register defaults.
// Receiver cannot stall; results leave in input order.
`include "quaternion_normalizer_unit_defines.svh"

module quaternion_normalizer_unit import qn_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [INDEX_BITS-1:0]       i_entry_index,
    input  logic signed [COMP_BITS-1:0] i_comp_w,
    input  logic signed [COMP_BITS-1:0] i_comp_x,
    input  logic signed [COMP_BITS-1:0] i_comp_y,
    input  logic signed [COMP_BITS-1:0] i_comp_z,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic                        o_done,
    output logic [INDEX_BITS-1:0]       o_out_index,
    output logic signed [COMP_BITS-1:0] o_res_w,
    output logic signed [COMP_BITS-1:0] o_res_x,
    output logic signed [COMP_BITS-1:0] o_res_y,
    output logic signed [COMP_BITS-1:0] o_res_z,
    output logic [1:0]                  o_outcome
);

    logic [REG_BITS-1:0] r_lim, r_tol;

    logic        r_vld [1:4];
    t_item       r_item [1:4];
    logic [63:0] sq [0:3];
    logic [64:0] r_pair [0:1];
    logic [64:0] r_sum;
    logic [64:0] r_diff;

    logic  r_svld [0:SIDE_DEPTH-1];
    t_side r_side [0:SIDE_DEPTH-1];
    t_side n_side0;
    t_side n_side1;

    logic [31:0]          root;
    logic [32:0]          mag;
    logic [DIV_STEPS-1:0] quot [0:3];

    t_side          fin;
    logic           r_done;
    t_item          r_res;
    t_outcome       r_outcome;
    t_quat          n_comp;
    t_outcome       n_outcome;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIM_RESET;
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NEAR_ZERO: r_lim <= i_cfg_data[REG_BITS-1:0];
                CFG_UNIT_TOL:  r_tol <= i_cfg_data[REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // front: capture, square, add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 4; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[1] <= i_start;
            for (int i = 2; i <= 4; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[1].index <= i_entry_index;
        r_item[1].comp  <= {i_comp_z, i_comp_y, i_comp_x, i_comp_w};
        for (int i = 2; i <= 4; i++) r_item[i] <= r_item[i-1];
        r_pair[0] <= {1'b0, sq[0]} + {1'b0, sq[1]};
        r_pair[1] <= {1'b0, sq[2]} + {1'b0, sq[3]};
        r_sum     <= r_pair[0] + r_pair[1];
    end

    for (genvar l = 0; l < 4; l++) begin : g_sq
        qn_square_lane u_sq (
            .i_clk  (i_clk),
            .i_comp (r_item[1].comp[l]),
            .o_sq   (sq[l])
        );
    end

    // classification
    always_comb begin
        n_side0.index     = r_item[4].index;
        n_side0.comp      = r_item[4].comp;
        n_side0.carry     = r_sum[64];
        n_side0.near_zero = !r_sum[64] && (r_sum < {8'b0, r_lim, 28'b0});
        n_side0.zero      = (r_sum == '0);
        n_side0.off_unit  = 1'b0;
    end

    always_comb begin
        n_side1          = r_side[0];
        n_side1.off_unit = r_side[0].carry || (r_diff > {8'b0, r_tol, 28'b0});
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side0;
        r_diff    <= (r_sum >= ONE_Q56) ? (r_sum - ONE_Q56) : (ONE_Q56 - r_sum);
        r_side[1] <= n_side1;
        for (int j = 2; j < SIDE_DEPTH; j++) r_side[j] <= r_side[j-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SIDE_DEPTH; j++) r_svld[j] <= 1'b0;
        end else begin
            r_svld[0] <= r_vld[4];
            for (int j = 1; j < SIDE_DEPTH; j++) r_svld[j] <= r_svld[j-1];
        end
    end

    qn_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_sum[63:0]),
        .o_root (root)
    );

    assign mag = r_side[M_TAP].carry ? 33'h1_0000_0000 : {1'b0, root};

    for (genvar l = 0; l < 4; l++) begin : g_div
        qn_div_lane u_div (
            .i_clk  (i_clk),
            .i_comp (r_side[M_TAP].comp[l]),
            .i_mag  (mag),
            .o_quot (quot[l])
        );
    end

    // merge lanes
    assign fin = r_side[SIDE_DEPTH-1];

    always_comb begin
        if (fin.near_zero || (fin.off_unit && fin.zero)) begin
            n_comp    = {32'b0, 32'b0, 32'b0, ONE_Q28};
            n_outcome = OUT_IDENTITY;
        end else if (fin.off_unit) begin
            for (int l = 0; l < 4; l++) begin
                n_comp[l] = fin.comp[l][COMP_BITS-1] ? (32'b0 - {3'b0, quot[l]})
                                                      : {3'b0, quot[l]};
            end
            n_outcome = OUT_RESCALED;
        end else begin
            n_comp    = fin.comp;
            n_outcome = OUT_UNCHANGED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_svld[SIDE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.index <= fin.index;
        r_res.comp  <= n_comp;
        r_outcome   <= n_outcome;
    end

    assign o_done      = r_done;
    assign o_out_index = r_res.index;
    assign o_res_w     = r_res.comp[0];
    assign o_res_x     = r_res.comp[1];
    assign o_res_y     = r_res.comp[2];
    assign o_res_z     = r_res.comp[3];
    assign o_outcome   = r_outcome;

    `QN_ASSERT_NOW(a_identity_word, o_done && (o_outcome == OUT_IDENTITY), (o_res_w == ONE_Q28) && (o_res_x == 0) && (o_res_y == 0) && (o_res_z == 0))
    `QN_ASSERT_NOW(a_rescale_bound, o_done && (o_outcome == OUT_RESCALED), (o_res_w <= $signed(ONE_Q28)) && (o_res_w >= -$signed(ONE_Q28)))
    `QN_ASSERT_NEXT(a_side_flow, r_vld[4], r_svld[0])

endmodule
